FILE: sv/pit_pkg.sv
// ----------------------------------------------------------------------------
// pit_pkg: shared types and constants for the timer channel latch/read block
// Holds the sequencer state type, the access kind, byte phase codes and the
// arithmetic constants of the tick conversion.
// ----------------------------------------------------------------------------
package pit_pkg;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_MOD,
        ST_CNT,
        ST_FIN
    } t_state;

    // Kind of an accepted access
    typedef enum logic [1:0] {
        KD_NONE,
        KD_LATCH,
        KD_READ
    } t_kind;

    // Configuration register indexes
    localparam logic [1:0] CFG_INITIAL_COUNT   = 2'd0;
    localparam logic [1:0] CFG_COUNTER_CHANNEL = 2'd1;
    localparam logic [1:0] CFG_ACCESS_MODE     = 2'd2;

    // Byte phase codes
    localparam logic [1:0] PH_HIGH_NEXT = 2'd0;
    localparam logic [1:0] PH_LOW_ONLY  = 2'd1;
    localparam logic [1:0] PH_HIGH_ONLY = 2'd2;
    localparam logic [1:0] PH_LOW_NEXT  = 2'd3;

    // Port addresses
    localparam logic [15:0] PORT_BASE = 16'h0040;
    localparam logic [15:0] PORT_MODE = 16'h0043;

    // Datapath widths
    localparam int unsigned NS_W   = 32;
    localparam int unsigned ACC_W  = 53;  // reciprocal and upper partial product fit in 53 bits
    localparam int unsigned QUO_W  = 23;  // ticks fit in 23 bits
    localparam int unsigned RLD_W  = 17;  // reload up to 65536
    localparam int unsigned STEP_W = 5;

    // Arithmetic constants
    localparam logic [ACC_W-1:0] TICK_HZ  = 53'd1193181;
    localparam logic [ACC_W-1:0] NS_PER_S = 53'd1000000000;

    // Ticks are (ns * TICK_RECIP) >> RCP_SHIFT, exact for every 32-bit ns
    localparam int unsigned RCP_SHIFT = 62;
    localparam logic [95:0] RCP_WIDE  =
        ((96'(TICK_HZ) << RCP_SHIFT) + 96'(NS_PER_S) - 96'd1) / 96'(NS_PER_S);
    localparam logic [ACC_W-1:0] TICK_RECIP = RCP_WIDE[ACC_W-1:0];
    // lowest tick bit inside the product that is already shifted down by NS_W
    localparam int unsigned TICK_LSB = RCP_SHIFT - NS_W;

    localparam logic [STEP_W-1:0] MUL_LAST_STEP = STEP_W'(NS_W - 1);
    localparam logic [STEP_W-1:0] QUO_LAST_STEP = STEP_W'(QUO_W - 1);

endpackage

FILE: sv/pit_counter_latch_read_top.sv
// ----------------------------------------------------------------------------
// pit_counter_latch_read_top: timer channel counter latch and byte read
// Decodes single I/O accesses, computes the running count with one shared
// add/subtract unit and returns the latched or live count byte by byte.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: i_in_valid / o_in_stall with one access per item. An item
//   is taken when valid is high and stall is low. The block takes one item at
//   a time and holds o_in_stall high while it works on it.
//   Output channel: o_out_valid / i_out_stall with one result per item
//   (o_handled, o_read_data), held in an output register until taken.
//   Sequence: a latch command or a read with no latch pending computes the
//   count: 32 reciprocal multiply steps, 23 modulo steps, one final subtract
//   and the update state, which loads the result into the output register.
//   Any other access goes from accept straight to the update state. The shared
//   54-bit adder does one multiply or modulo step per cycle.
//   Flow: the next item can be taken while a result still waits in the output
//   register.
//   Stall: a stalled result holds; the block finishes its next item only when
//   the output register is free.
//   Reset (synchronous, active low) restores the register defaults, puts the
//   byte phase at low-byte-next and clears the latch flags and held count.
//   Configuration is written through i_cfg_we / i_cfg_idx / i_cfg_data.
// ----------------------------------------------------------------------------
module pit_counter_latch_read_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_req_type,
    input  logic [15:0] i_port_addr,
    input  logic [2:0]  i_access_size,
    input  logic        i_string_op,
    input  logic        i_memory_mapped,
    input  logic [7:0]  i_write_data,
    input  logic [31:0] i_elapsed_ns,
    // output channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_handled,
    output logic [7:0]  o_read_data
);

    localparam int unsigned ACC_W    = pit_pkg::ACC_W;
    localparam int unsigned QUO_W    = pit_pkg::QUO_W;
    localparam int unsigned RLD_W    = pit_pkg::RLD_W;
    localparam int unsigned NS_W     = pit_pkg::NS_W;
    localparam int unsigned STEP_W   = pit_pkg::STEP_W;
    localparam int unsigned TICK_LSB = pit_pkg::TICK_LSB;

    // configuration and channel state
    logic [15:0]        r_initial;
    logic [1:0]         r_channel;
    logic [1:0]         r_phase,  n_phase;
    logic [15:0]        r_held,   n_held;
    logic               r_low_l,  n_low_l;
    logic               r_high_l, n_high_l;

    // sequencer and datapath
    pit_pkg::t_state    r_state,  n_state;
    pit_pkg::t_kind     r_kind,   n_kind;
    logic [STEP_W-1:0]  r_step,   n_step;
    logic [NS_W-1:0]    r_ns,     n_ns;
    logic [ACC_W-1:0]   r_acc,    n_acc;
    logic [QUO_W-1:0]   r_quo,    n_quo;

    // output register
    logic               r_out_valid, n_out_valid;
    logic               r_handled,   n_handled;
    logic [7:0]         r_rdata,     n_rdata;

    // shared add/subtract unit
    logic [ACC_W-1:0]   alu_a;
    logic [ACC_W-1:0]   alu_b;
    logic               alu_sub;
    logic [ACC_W:0]     alu_sum;
    logic               alu_ge;

    logic               in_acc;
    logic               out_acc;
    logic               acc_ok;
    logic               is_latch;
    logic               is_read;
    logic [RLD_W-1:0]   reload;
    logic [ACC_W-1:0]   mod_a;
    logic [15:0]        count;
    logic [15:0]        value;
    logic               take_low;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_acc  = r_out_valid && !i_out_stall;
    assign reload   = (r_initial == 16'd0) ? RLD_W'(17'h10000) : {1'b0, r_initial};
    assign count    = r_acc[15:0];

    // decode the incoming access
    assign acc_ok   = (i_access_size == 3'd1) && !i_string_op && !i_memory_mapped;
    assign is_latch = acc_ok && (i_port_addr == pit_pkg::PORT_MODE) && !i_req_type
                      && (i_write_data[5:4] == 2'b00) && (i_write_data[7:6] == r_channel);
    assign is_read  = acc_ok && i_req_type
                      && (i_port_addr == (pit_pkg::PORT_BASE + {14'd0, r_channel}));

    // modulo step operand: remainder shifted left with the next tick bit
    assign mod_a    = {{(ACC_W-RLD_W-1){1'b0}}, r_acc[RLD_W-1:0], r_quo[QUO_W-1]};

    // shared unit
    assign alu_sum  = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)}
                      + {{ACC_W{1'b0}}, alu_sub};
    assign alu_ge   = alu_sum[ACC_W];

    assign o_in_stall  = (r_state != pit_pkg::ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_handled   = r_handled;
    assign o_read_data = r_rdata;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pit_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state, unit operands and datapath
    always_comb begin
        n_state     = r_state;
        n_kind      = r_kind;
        n_step      = r_step;
        n_ns        = r_ns;
        n_acc       = r_acc;
        n_quo       = r_quo;
        n_phase     = r_phase;
        n_held      = r_held;
        n_low_l     = r_low_l;
        n_high_l    = r_high_l;
        n_out_valid = out_acc ? 1'b0 : r_out_valid;
        n_handled   = r_handled;
        n_rdata     = r_rdata;
        alu_a       = r_acc;
        alu_b       = {{(ACC_W-RLD_W){1'b0}}, reload};
        alu_sub     = 1'b1;
        value       = r_held;
        take_low    = 1'b1;

        case (r_state)
            pit_pkg::ST_IDLE: begin
                // take an item, start the count only when it is needed
                if (in_acc) begin
                    n_ns   = i_elapsed_ns;
                    n_acc  = '0;
                    n_step = pit_pkg::MUL_LAST_STEP;
                    if (is_latch) begin
                        n_kind  = pit_pkg::KD_LATCH;
                        n_state = pit_pkg::ST_MUL;
                    end else if (is_read) begin
                        n_kind  = pit_pkg::KD_READ;
                        n_state = (r_low_l || r_high_l) ? pit_pkg::ST_FIN : pit_pkg::ST_MUL;
                    end else begin
                        n_kind  = pit_pkg::KD_NONE;
                        n_state = pit_pkg::ST_FIN;
                    end
                end
            end
            pit_pkg::ST_MUL: begin
                // add the scaled reciprocal, elapsed time LSB first, keep the upper bits
                alu_a   = r_acc;
                alu_b   = r_ns[0] ? pit_pkg::TICK_RECIP : '0;
                alu_sub = 1'b0;
                n_acc   = alu_sum[ACC_W:1];
                n_ns    = {1'b0, r_ns[NS_W-1:1]};
                n_step  = r_step - 1'b1;
                if (r_step == '0) begin
                    n_quo   = alu_sum[TICK_LSB+1 +: QUO_W];
                    n_acc   = '0;
                    n_step  = pit_pkg::QUO_LAST_STEP;
                    n_state = pit_pkg::ST_MOD;
                end
            end
            pit_pkg::ST_MOD: begin
                // restoring remainder of ticks by the reload value
                alu_a  = mod_a;
                alu_b  = {{(ACC_W-RLD_W){1'b0}}, reload};
                n_acc  = alu_ge ? alu_sum[ACC_W-1:0] : mod_a;
                n_quo  = {r_quo[QUO_W-2:0], 1'b0};
                n_step = r_step - 1'b1;
                if (r_step == '0) begin
                    n_state = pit_pkg::ST_CNT;
                end
            end
            pit_pkg::ST_CNT: begin
                // count is reload minus remainder
                alu_a   = {{(ACC_W-RLD_W){1'b0}}, reload};
                alu_b   = r_acc;
                n_acc   = alu_sum[ACC_W-1:0];
                n_state = pit_pkg::ST_FIN;
            end
            pit_pkg::ST_FIN: begin
                // update channel state and load the result when the output is free
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_handled   = 1'b0;
                    n_rdata     = 8'd0;
                    n_state     = pit_pkg::ST_IDLE;
                    case (r_kind)
                        pit_pkg::KD_LATCH: begin
                            n_handled = 1'b1;
                            n_held    = count;
                            if (r_phase == pit_pkg::PH_HIGH_ONLY) begin
                                n_high_l = 1'b1;
                            end else if (r_phase == pit_pkg::PH_LOW_ONLY) begin
                                n_low_l = 1'b1;
                            end else begin
                                n_phase  = pit_pkg::PH_LOW_NEXT;
                                n_low_l  = 1'b1;
                                n_high_l = 1'b1;
                            end
                        end
                        pit_pkg::KD_READ: begin
                            n_handled = 1'b1;
                            if (r_low_l) begin
                                n_low_l  = 1'b0;
                                take_low = 1'b1;
                            end else if (r_high_l) begin
                                n_high_l = 1'b0;
                                take_low = 1'b0;
                            end else begin
                                n_held   = count;
                                value    = count;
                                take_low = (r_phase == pit_pkg::PH_LOW_ONLY)
                                           || (r_phase == pit_pkg::PH_LOW_NEXT);
                            end
                            if (take_low) begin
                                n_rdata = value[7:0];
                                if (r_phase == pit_pkg::PH_LOW_NEXT) begin
                                    n_phase = pit_pkg::PH_HIGH_NEXT;
                                end
                            end else begin
                                n_rdata = value[15:8];
                                if (r_phase == pit_pkg::PH_HIGH_NEXT) begin
                                    n_phase = pit_pkg::PH_LOW_NEXT;
                                end
                            end
                        end
                        default: begin
                            n_handled = 1'b0;
                        end
                    endcase
                end
            end
            default: begin
                n_state = pit_pkg::ST_IDLE;
            end
        endcase

        // access mode write: drop both latches, set the byte phase, ignore mode zero
        if (i_cfg_we && (i_cfg_idx == pit_pkg::CFG_ACCESS_MODE)) begin
            n_low_l  = 1'b0;
            n_high_l = 1'b0;
            if (i_cfg_data[1:0] != 2'd0) begin
                n_phase = i_cfg_data[1:0];
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_kind  <= n_kind;
        r_step  <= n_step;
        r_ns    <= n_ns;
        r_acc   <= n_acc;
        r_quo   <= n_quo;
        r_handled <= n_handled;
        r_rdata   <= n_rdata;
    end

    // control registers, channel state and configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_initial   <= 16'hFFFF;
            r_channel   <= 2'd0;
            r_phase     <= pit_pkg::PH_LOW_NEXT;
            r_held      <= 16'd0;
            r_low_l     <= 1'b0;
            r_high_l    <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            r_phase     <= n_phase;
            r_held      <= n_held;
            r_low_l     <= n_low_l;
            r_high_l    <= n_high_l;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    pit_pkg::CFG_INITIAL_COUNT: begin
                        r_initial <= i_cfg_data;
                    end
                    pit_pkg::CFG_COUNTER_CHANNEL: begin
                        r_channel <= i_cfg_data[1:0];
                    end
                    default: ;
                endcase
            end
        end
    end

    // a new result comes only out of the update cycle
    a_out_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == pit_pkg::ST_FIN))
        else $error("result appeared outside the update cycle");

    // an access that is not handled returns a zero byte
    a_unhandled_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_handled) |-> (o_read_data == 8'd0))
        else $error("unhandled access returned data");

    // both bytes latched only with the low byte next
    a_latch_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_low_l && r_high_l) |-> (r_phase == pit_pkg::PH_LOW_NEXT))
        else $error("both latches set with wrong byte phase");

    // a held result stays while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_read_data)))
        else $error("stalled result changed");

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the timer channel latch/read block
// Feeds directed and random I/O accesses through the valid/stall input
// channel and predicts every result from a behavioral copy of the channel
// state. The results on the output channel are checked in order. Both sides
// idle at random, and the registers are rewritten between phases once the
// block has gone quiet.
// ----------------------------------------------------------------------------
module tb_top;

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_READ  = 1'b1;
    localparam int   CYCLE_LIMIT = 1000000;
    localparam int   RAND_PHASES = 8;
    localparam int   ITEMS_PER_PHASE = 78;

    typedef struct packed {
        logic        req_type;
        logic [15:0] port_addr;
        logic [2:0]  access_size;
        logic        string_op;
        logic        memory_mapped;
        logic [7:0]  write_data;
        logic [31:0] elapsed_ns;
    } t_access;

    typedef struct packed {
        logic       handled;
        logic [7:0] read_data;
    } t_result;

    // Clock, reset and block inputs, all known from time zero
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_idx = '0;
    logic [15:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    t_access     drv_item = '0;
    logic        out_stall = 1'b0;

    logic        o_in_stall;
    logic        o_out_valid;
    logic        o_handled;
    logic [7:0]  o_read_data;

    // Channel state of the predictor
    logic [15:0] m_initial;
    logic [1:0]  m_channel;
    logic [1:0]  m_phase;
    logic [15:0] m_held;
    logic        m_low_latched;
    logic        m_high_latched;

    t_access pending_q[$];
    t_result expected_q[$];

    int      err_count = 0;
    int      cycle_count = 0;
    int      gap_left = 0;
    int      stall_left = 0;
    bit      drv_quiet = 1'b0;
    bit      mon_quiet = 1'b0;
    t_result got;
    t_result want;

    pit_counter_latch_read_top DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (in_valid),
        .o_in_stall      (o_in_stall),
        .i_req_type      (drv_item.req_type),
        .i_port_addr     (drv_item.port_addr),
        .i_access_size   (drv_item.access_size),
        .i_string_op     (drv_item.string_op),
        .i_memory_mapped (drv_item.memory_mapped),
        .i_write_data    (drv_item.write_data),
        .i_elapsed_ns    (drv_item.elapsed_ns),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (out_stall),
        .o_handled       (o_handled),
        .o_read_data     (o_read_data)
    );

    // Idle length: mostly none, some short, a few long
    function automatic int pick_idle();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 150);
    endfunction

    // Running count at a given time since period start
    function automatic logic [15:0] count_at(logic [31:0] ns);
        logic [63:0] reload;
        logic [63:0] ticks;
        logic [63:0] diff;
        reload = (m_initial == 16'd0) ? 64'd65536 : 64'(m_initial);
        ticks  = (64'(ns) * 64'(pit_pkg::TICK_HZ)) / 64'(pit_pkg::NS_PER_S);
        diff   = reload - (ticks % reload);
        return diff[15:0];
    endfunction

    // Apply one access to the channel state and form its result
    task automatic predict_access(input t_access a, output t_result r);
        logic        take_low;
        logic [15:0] val;
        r = '0;
        if (a.access_size == 3'd1 && !a.string_op && !a.memory_mapped) begin
            if (a.port_addr == pit_pkg::PORT_MODE && a.req_type == REQ_WRITE &&
                a.write_data[5:4] == 2'b00 && a.write_data[7:6] == m_channel) begin
                // latch command: hold the count, flag bytes by phase
                m_held = count_at(a.elapsed_ns);
                case (m_phase)
                    pit_pkg::PH_HIGH_ONLY: m_high_latched = 1'b1;
                    pit_pkg::PH_LOW_ONLY:  m_low_latched = 1'b1;
                    default: begin
                        m_phase = pit_pkg::PH_LOW_NEXT;
                        m_low_latched = 1'b1;
                        m_high_latched = 1'b1;
                    end
                endcase
                r.handled = 1'b1;
            end else if (a.port_addr == pit_pkg::PORT_BASE + 16'(m_channel) &&
                         a.req_type == REQ_READ) begin
                // latched bytes first, else a live count
                if (m_low_latched) begin
                    m_low_latched = 1'b0;
                    take_low = 1'b1;
                    val = m_held;
                end else if (m_high_latched) begin
                    m_high_latched = 1'b0;
                    take_low = 1'b0;
                    val = m_held;
                end else begin
                    m_held = count_at(a.elapsed_ns);
                    val = m_held;
                    take_low = (m_phase == pit_pkg::PH_LOW_ONLY ||
                                m_phase == pit_pkg::PH_LOW_NEXT);
                end
                if (take_low) begin
                    if (m_phase == pit_pkg::PH_LOW_NEXT) m_phase = pit_pkg::PH_HIGH_NEXT;
                    r.read_data = val[7:0];
                end else begin
                    if (m_phase == pit_pkg::PH_HIGH_NEXT) m_phase = pit_pkg::PH_LOW_NEXT;
                    r.read_data = val[15:8];
                end
                r.handled = 1'b1;
            end
        end
    endtask

    // Write one register and mirror it in the predictor
    task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        case (idx)
            pit_pkg::CFG_INITIAL_COUNT:   m_initial = data;
            pit_pkg::CFG_COUNTER_CHANNEL: m_channel = data[1:0];
            pit_pkg::CFG_ACCESS_MODE: begin
                m_low_latched = 1'b0;
                m_high_latched = 1'b0;
                if (data[1:0] != 2'd0) m_phase = data[1:0];
            end
            default: ;
        endcase
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic queue_access(input logic req, input logic [15:0] port,
                                input logic [2:0] size, input logic str,
                                input logic mm, input logic [7:0] data,
                                input logic [31:0] ns);
        t_access a;
        a = '{req, port, size, str, mm, data, ns};
        pending_q.push_back(a);
    endtask

    // Wait until every queued item has gone through and been answered
    task automatic wait_drained();
        while (pending_q.size() != 0 || in_valid || expected_q.size() != 0)
            @(posedge i_clk);
    endtask

    // Clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Cycle limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Driver: present pending items, predict each one as it is taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            gap_left = 0;
        end else begin
            if (in_valid && !o_in_stall) begin
                predict_access(drv_item, got);
                expected_q.push_back(got);
            end
            if (!in_valid || !o_in_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_valid <= 1'b0;
                end else if (pending_q.size() != 0) begin
                    drv_item <= pending_q.pop_front();
                    in_valid <= 1'b1;
                    if ($urandom_range(0, 39) == 0) drv_quiet = !drv_quiet;
                    gap_left = drv_quiet ? 0 : pick_idle();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each taken result against the oldest expectation
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_stall <= 1'b0;
            stall_left = 0;
        end else begin
            if (o_out_valid && !out_stall) begin
                if (expected_q.size() == 0) begin
                    err_count++;
                    if (err_count <= 10)
                        $display("tb: unexpected result handled=%0d read_data=%02h",
                                 o_handled, o_read_data);
                end else begin
                    want = expected_q.pop_front();
                    if (o_handled !== want.handled || o_read_data !== want.read_data) begin
                        err_count++;
                        if (err_count <= 10)
                            $display({"tb: mismatch exp handled=%0d read_data=%02h, ",
                                      "got handled=%0d read_data=%02h"},
                                     want.handled, want.read_data, o_handled, o_read_data);
                    end
                end
                if ($urandom_range(0, 29) == 0) mon_quiet = !mon_quiet;
                if (!mon_quiet) stall_left = pick_idle();
            end else if (stall_left == 0 && !mon_quiet && $urandom_range(0, 15) == 0) begin
                stall_left = pick_idle();
            end
            if (stall_left > 0) begin
                out_stall <= 1'b1;
                stall_left--;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    // Stimulus and end of run
    initial begin
        t_access     a;
        int          sel;
        logic [15:0] set_count;
        logic [1:0]  set_chan;
        logic [1:0]  set_mode;

        m_initial = 16'd65535;
        m_channel = 2'd0;
        m_phase = pit_pkg::PH_LOW_NEXT;
        m_held = '0;
        m_low_latched = 1'b0;
        m_high_latched = 1'b0;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reset settings, channel 0, low then high
        queue_access(REQ_READ,  pit_pkg::PORT_BASE, 3'd1, 1'b0, 1'b0, 8'h00, 32'd0);
        queue_access(REQ_READ,  pit_pkg::PORT_BASE, 3'd1, 1'b0, 1'b0, 8'hFF, 32'hFFFF_FFFF);
        queue_access(REQ_WRITE, pit_pkg::PORT_MODE, 3'd1, 1'b0, 1'b0, 8'h00, 32'd1000000000);
        queue_access(REQ_READ,  pit_pkg::PORT_BASE, 3'd1, 1'b0, 1'b0, 8'h00, 32'd5);
        queue_access(REQ_READ,  pit_pkg::PORT_BASE, 3'd1, 1'b0, 1'b0, 8'h00, 32'd6);
        // latch while the high byte is next
        queue_access(REQ_READ,  pit_pkg::PORT_BASE, 3'd1, 1'b0, 1'b0, 8'h00, 32'd5000);
        queue_access(REQ_WRITE, pit_pkg::PORT_MODE, 3'd1, 1'b0, 1'b0, 8'h0F, 32'd777777);
        queue_access(REQ_READ,  pit_pkg::PORT_BASE, 3'd1, 1'b0, 1'b0, 8'h00, 32'd0);
        queue_access(REQ_READ,  pit_pkg::PORT_BASE, 3'd1, 1'b0, 1'b0, 8'h00, 32'd0);
        // repeated latch overwrites the held count
        queue_access(REQ_WRITE, pit_pkg::PORT_MODE, 3'd1, 1'b0, 1'b0, 8'h00, 32'd100);
        queue_access(REQ_WRITE, pit_pkg::PORT_MODE, 3'd1, 1'b0, 1'b0, 8'h00, 32'd3000000000);
        queue_access(REQ_READ,  pit_pkg::PORT_BASE, 3'd1, 1'b0, 1'b0, 8'h00, 32'd1);
        queue_access(REQ_READ,  pit_pkg::PORT_BASE, 3'd1, 1'b0, 1'b0, 8'h00, 32'd1);
        // accesses that are not handled, then a live read that is
        queue_access(REQ_READ,  pit_pkg::PORT_BASE, 3'd2, 1'b0, 1'b0, 8'h00, 32'd10);
        queue_access(REQ_READ,  pit_pkg::PORT_BASE, 3'd4, 1'b0, 1'b0, 8'h00, 32'd10);
        queue_access(REQ_READ,  pit_pkg::PORT_BASE, 3'd0, 1'b0, 1'b0, 8'h00, 32'd10);
        queue_access(REQ_WRITE, pit_pkg::PORT_MODE, 3'd7, 1'b0, 1'b0, 8'h00, 32'd10);
        queue_access(REQ_READ,  pit_pkg::PORT_BASE, 3'd1, 1'b1, 1'b0, 8'h00, 32'd10);
        queue_access(REQ_WRITE, pit_pkg::PORT_MODE, 3'd1, 1'b0, 1'b1, 8'h00, 32'd10);
        queue_access(REQ_WRITE, pit_pkg::PORT_BASE, 3'd1, 1'b0, 1'b0, 8'h00, 32'd10);
        queue_access(REQ_READ,  pit_pkg::PORT_MODE, 3'd1, 1'b0, 1'b0, 8'h00, 32'd10);
        queue_access(REQ_WRITE, pit_pkg::PORT_MODE, 3'd1, 1'b0, 1'b0, 8'h40, 32'd10);
        queue_access(REQ_WRITE, pit_pkg::PORT_MODE, 3'd1, 1'b0, 1'b0, 8'h30, 32'd10);
        queue_access(REQ_READ,  16'h0041,           3'd1, 1'b0, 1'b0, 8'h00, 32'd10);
        queue_access(REQ_READ,  pit_pkg::PORT_BASE, 3'd1, 1'b0, 1'b0, 8'h00, 32'd20);
        wait_drained();

        // Random phases, each under new register settings
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            case (ph)
                0: begin set_count = 16'd1;     set_chan = 2'd0; set_mode = 2'd3; end
                1: begin set_count = 16'd0;     set_chan = 2'd3; set_mode = 2'd1; end
                2: begin set_count = 16'd65535; set_chan = 2'd2; set_mode = 2'd2; end
                3: begin set_count = 16'($urandom); set_chan = 2'd1; set_mode = 2'd0; end
                4: begin set_count = 16'($urandom); set_chan = 2'd3; set_mode = 2'd3; end
                5: begin set_count = 16'd2;     set_chan = 2'd1; set_mode = 2'd1; end
                6: begin set_count = 16'($urandom_range(1, 300)); set_chan = 2'd0;
                          set_mode = 2'd2; end
                default: begin
                    set_count = 16'($urandom);
                    set_chan = 2'($urandom);
                    set_mode = 2'($urandom);
                end
            endcase
            write_reg(pit_pkg::CFG_INITIAL_COUNT, set_count);
            write_reg(pit_pkg::CFG_COUNTER_CHANNEL, {14'($urandom), set_chan});
            write_reg(pit_pkg::CFG_ACCESS_MODE, {14'($urandom), set_mode});

            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                a = '0;
                a.access_size = 3'd1;
                a.write_data = 8'($urandom);
                sel = $urandom_range(0, 99);
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5: a.elapsed_ns = $urandom;
                    6, 7:             a.elapsed_ns = $urandom_range(0, 5000000);
                    8:                a.elapsed_ns = $urandom_range(0, 1000);
                    default:          a.elapsed_ns = 32'hFFFF_FF00 | 32'($urandom_range(0, 255));
                endcase
                if (sel < 40) begin
                    // read of this channel's counter port
                    a.req_type = REQ_READ;
                    a.port_addr = pit_pkg::PORT_BASE + 16'(m_channel);
                end else if (sel < 65) begin
                    // latch command for this channel
                    a.req_type = REQ_WRITE;
                    a.port_addr = pit_pkg::PORT_MODE;
                    a.write_data = {m_channel, 2'b00, 4'($urandom)};
                end else if (sel < 75) begin
                    // any byte written to the mode port
                    a.req_type = REQ_WRITE;
                    a.port_addr = pit_pkg::PORT_MODE;
                end else begin
                    // noise: any field may be off
                    a.req_type = 1'($urandom);
                    a.port_addr = ($urandom_range(0, 3) == 0) ? 16'($urandom) :
                                  pit_pkg::PORT_BASE + 16'($urandom_range(0, 3));
                    a.access_size = 3'($urandom_range(0, 7));
                    a.string_op = ($urandom_range(0, 3) == 0);
                    a.memory_mapped = ($urandom_range(0, 3) == 0);
                end
                pending_q.push_back(a);
            end
            // hold the sender until the block has answered everything
            wait_drained();
        end

        repeat (100) @(posedge i_clk);
        if (err_count == 0 && expected_q.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
